[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the body extractor checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset
`define HRBE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define HRBE_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/hrbe_pkg.sv]
// ---------------------------------------------------------------------------
// hrbe_pkg
// Types, character constants and field widths for the HTTP body extractor.
// ---------------------------------------------------------------------------
package hrbe_pkg;

    // Counter width default (range 8 to 64)
    localparam int LENGTH_BITS_DEFAULT = 32;

    // Fixed widths of the stream fields
    localparam int BYTE_W  = 8;
    localparam int ANN_W   = 32;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 48;

    // Header keyword and terminator
    localparam int KW_LEN     = 16;
    localparam int KW_IDX_W   = 4;
    localparam int TERM_LEN   = 4;
    localparam int TERM_IDX_W = 2;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_0  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9  = 8'h39;

    // "Content-Length: "
    localparam logic [BYTE_W-1:0] KEYWORD [KW_LEN] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
    };

    localparam logic [BYTE_W-1:0] TERMINATOR [TERM_LEN] = '{
        CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF
    };

    // Parse phase
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    // One accepted input byte
    typedef struct packed {
        logic              start_of_response;
        logic [BYTE_W-1:0] rx_byte;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic              body_valid;
        logic [BYTE_W-1:0] body_byte;
        logic              body_last;
        phase_t            phase;
        logic              length_found;
        logic [ANN_W-1:0]  announced_length;
    } result_t;

endpackage

[hw/rtl/hrbe_in_stage.sv]
// ---------------------------------------------------------------------------
// hrbe_in_stage
// Input register: captures one byte transfer and holds it until the parser
// hands it on to the result register.
// ---------------------------------------------------------------------------
module hrbe_in_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hrbe_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  logic                           advance,
    output logic                           item_valid,
    output hrbe_pkg::in_item_t             item
);
    import hrbe_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Take a new byte whenever the held one leaves or none is held
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load the payload on each input transfer
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.start_of_response <= s_tuser;
            item_reg.rx_byte           <= s_tdata[BYTE_W-1:0];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hw/rtl/hrbe_parser.sv]
// ---------------------------------------------------------------------------
// hrbe_parser
// Parse state and per-byte update: keyword and terminator matchers, decimal
// length accumulator, body byte counter and phase sequencing.
// ---------------------------------------------------------------------------
module hrbe_parser #(
    parameter int LENGTH_BITS = hrbe_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  hrbe_pkg::in_item_t item,
    output hrbe_pkg::result_t  result
);
    import hrbe_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    // State registers
    phase_t                  phase_reg,   phase_next;
    logic [TERM_IDX_W-1:0]   term_reg,    term_next;
    logic [KW_IDX_W-1:0]     kw_reg,      kw_next;
    logic                    reading_reg, reading_next;
    logic                    seen_reg,    seen_next;
    logic [LENGTH_BITS-1:0]  len_reg,     len_next;
    logic [LENGTH_BITS-1:0]  passed_reg,  passed_next;

    // State as seen by this byte, after an optional restart
    phase_t                  phase_cur;
    logic [TERM_IDX_W-1:0]   term_cur;
    logic [KW_IDX_W-1:0]     kw_cur;
    logic                    reading_cur;
    logic                    seen_cur;
    logic [LENGTH_BITS-1:0]  len_cur;
    logic [LENGTH_BITS-1:0]  passed_cur;

    logic [BYTE_W-1:0]        rx;
    logic [LENGTH_BITS+3:0]   len_scaled;
    logic                     term_hit;
    logic                     body_done;
    logic [LENGTH_BITS+ANN_W-1:0] len_ext;

    assign rx = item.rx_byte;

    // Restart clears everything before the byte is handled
    always_comb begin
        if (item.start_of_response) begin
            phase_cur   = PH_HEADER;
            term_cur    = '0;
            kw_cur      = '0;
            reading_cur = 1'b0;
            seen_cur    = 1'b0;
            len_cur     = '0;
            passed_cur  = '0;
        end else begin
            phase_cur   = phase_reg;
            term_cur    = term_reg;
            kw_cur      = kw_reg;
            reading_cur = reading_reg;
            seen_cur    = seen_reg;
            len_cur     = len_reg;
            passed_cur  = passed_reg;
        end
    end

    // length * 10 + digit; the digit is the low nibble of an ASCII digit
    assign len_scaled = ({4'b0, len_cur} << 3) + ({4'b0, len_cur} << 1)
                      + {{LENGTH_BITS{1'b0}}, rx[3:0]};

    // Matchers and counters
    always_comb begin
        term_next    = term_cur;
        kw_next      = kw_cur;
        reading_next = reading_cur;
        seen_next    = seen_cur;
        len_next     = len_cur;
        passed_next  = passed_cur;
        term_hit     = 1'b0;
        body_done    = 1'b0;

        if (phase_cur == PH_HEADER) begin
            // Accumulate digits, saturating; any other byte ends the run
            if (reading_cur) begin
                if (rx inside {[CHAR_0:CHAR_9]}) begin
                    if (len_scaled[LENGTH_BITS+3:LENGTH_BITS] != 4'b0) begin
                        len_next = LEN_MAX;
                    end else begin
                        len_next = len_scaled[LENGTH_BITS-1:0];
                    end
                end else begin
                    reading_next = 1'b0;
                end
            end

            // Search the keyword until its first occurrence
            if (!seen_cur) begin
                if (rx == KEYWORD[kw_cur]) begin
                    if (kw_cur == KW_IDX_W'(KW_LEN - 1)) begin
                        seen_next    = 1'b1;
                        reading_next = 1'b1;
                        kw_next      = '0;
                    end else begin
                        kw_next = kw_cur + KW_IDX_W'(1);
                    end
                end else if (rx == KEYWORD[0]) begin
                    kw_next = KW_IDX_W'(1);
                end else begin
                    kw_next = '0;
                end
            end

            // Watch for the blank line that closes the header
            if (rx == TERMINATOR[term_cur]) begin
                if (term_cur == TERM_IDX_W'(TERM_LEN - 1)) begin
                    term_next    = '0;
                    term_hit     = 1'b1;
                    reading_next = 1'b0;
                end else begin
                    term_next = term_cur + TERM_IDX_W'(1);
                end
            end else if (rx == CHAR_CR) begin
                term_next = TERM_IDX_W'(1);
            end else begin
                term_next = '0;
            end
        end else if (phase_cur == PH_BODY) begin
            // Count body bytes, wrapping at the counter width
            passed_next = passed_cur + LENGTH_BITS'(1);
            body_done   = (passed_next >= len_cur);
        end
    end

    // Phase sequencing
    always_comb begin
        case (phase_cur)
            PH_HEADER: begin
                if (term_hit) begin
                    phase_next = (seen_next && (len_next != '0)) ? PH_BODY : PH_DONE;
                end else begin
                    phase_next = PH_HEADER;
                end
            end
            PH_BODY:   phase_next = body_done ? PH_DONE : PH_BODY;
            PH_DONE:   phase_next = PH_DONE;
            default:   phase_next = PH_HEADER;
        endcase
    end

    assign len_ext = {{ANN_W{1'b0}}, len_next};

    // Result for this byte
    always_comb begin
        result.body_valid       = (phase_cur == PH_BODY);
        result.body_byte        = (phase_cur == PH_BODY) ? rx : '0;
        result.body_last        = body_done;
        result.phase            = phase_next;
        result.length_found     = seen_next;
        result.announced_length = len_ext[ANN_W-1:0];
    end

    // Commit state when the byte moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            term_reg    <= '0;
            kw_reg      <= '0;
            reading_reg <= 1'b0;
            seen_reg    <= 1'b0;
            len_reg     <= '0;
            passed_reg  <= '0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            term_reg    <= term_next;
            kw_reg      <= kw_next;
            reading_reg <= reading_next;
            seen_reg    <= seen_next;
            len_reg     <= len_next;
            passed_reg  <= passed_next;
        end
    end

endmodule

[hw/rtl/hrbe_out_stage.sv]
// ---------------------------------------------------------------------------
// hrbe_out_stage
// Result register: holds one result until the downstream side takes it and
// packs it onto the master stream.
// ---------------------------------------------------------------------------
module hrbe_out_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  hrbe_pkg::result_t              result,
    output logic                           can_load,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hrbe_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);
    import hrbe_pkg::*;

    localparam int PAD_W = M_TDATA_W - (BYTE_W + 2 + 1 + ANN_W);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Free when empty or when the held result leaves this cycle
    assign can_load   = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

    // Pack: body_byte, phase, length_found, announced_length, zero fill
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, res_reg.announced_length, res_reg.length_found,
                       res_reg.phase, res_reg.body_byte};
    assign m_tlast  = res_reg.body_last;
    assign m_tuser  = res_reg.body_valid;

endmodule

[hw/rtl/http_response_body_extractor_top.sv]
// ---------------------------------------------------------------------------
// http_response_body_extractor_top
// Byte-wide HTTP response parser that extracts the body using Content-Length.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream takes one response byte per transfer in s_tdata; s_tuser
//   high restarts the parse before that byte is handled.
//   Master stream gives one result per input byte: m_tuser marks a body
//   byte, m_tlast the byte that completes the announced length, and m_tdata
//   carries the byte, the phase after it, the length-found flag and the
//   length parsed so far.
//   A byte passes the input register, then the result register; one byte
//   is taken every cycle while the receiver keeps up, since the parse
//   state updates in a single step per byte.
//   Reset clears the parse state to header phase and empties both
//   registers. When the receiver stalls, the result is held, the input
//   register still fills, and s_tready drops once both are occupied.
//   After the header with no or zero length, and after the last body byte,
//   bytes give non-body results until the next restart.
// ---------------------------------------------------------------------------
module http_response_body_extractor_top #(
    parameter int LENGTH_BITS = hrbe_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hrbe_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] rx_byte
    input  logic                           s_tuser,   // [0] start_of_response
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hrbe_pkg::M_TDATA_W-1:0] m_tdata,   // [7:0] body_byte,
                                                      // [9:8] phase,
                                                      // [10] length_found,
                                                      // [42:11] announced_length,
                                                      // [47:43] zero
    output logic                           m_tlast,   // body_last
    output logic                           m_tuser    // [0] body_valid
);
    import hrbe_pkg::*;

    logic     item_valid;
    in_item_t item;
    logic     out_free;
    logic     advance;
    result_t  result;

    // Move a byte through the parser when the result register is free
    assign advance = item_valid && out_free;

    hrbe_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    hrbe_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    hrbe_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .can_load (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[hw/rtl/hrbe_checker.sv]
// ---------------------------------------------------------------------------
// hrbe_checker
// Port-level checks on the body extractor's result stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hrbe_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [hrbe_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast,
    input logic                           m_tuser
);
    import hrbe_pkg::*;

    // Last only on a body byte, and it ends the response
    `HRBE_ASSERT(a_last_is_body, aclk, aresetn, m_tvalid && m_tlast |-> m_tuser && (m_tdata[9:8] == PH_DONE), "last marker outside body or phase not finished")

    // Non-body results carry a zero byte
    `HRBE_ASSERT(a_idle_byte_zero, aclk, aresetn, m_tvalid && !m_tuser |-> m_tdata[7:0] == '0, "non-body result carries a byte")

    // A body byte never leaves the block in header phase
    `HRBE_NEVER(a_body_in_header, aclk, aresetn, m_tvalid && m_tuser && (m_tdata[9:8] == PH_HEADER), "body byte reported in header phase")

    // A body byte implies a length was found
    `HRBE_ASSERT(a_body_needs_len, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata[10], "body byte without a length field")

    // A stalled result holds
    `HRBE_ASSERT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result changed while stalled")

endmodule

bind http_response_body_extractor_top hrbe_checker u_hrbe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
